// ===== hw/rtl/i2c_target_byte_receiver_defines.svh =====
// assertion macros for the i2c target byte receiver
`ifndef I2C_TARGET_BYTE_RECEIVER_DEFINES_SVH
`define I2C_TARGET_BYTE_RECEIVER_DEFINES_SVH

// property holds on every rising clock edge outside reset
`define I2C_TBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be true outside reset
`define I2C_TBR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/i2c_tbr_pkg.sv =====
// types, codes and helpers shared by the i2c target byte receiver files
`default_nettype none

package i2c_tbr_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CountW = 4;

  localparam logic [AddrW-1:0] OwnAddrReset = 7'd80;

  // phase codes as seen on the bus_phase field
  localparam logic [PhaseW-1:0] CodeIdle     = 3'd0;
  localparam logic [PhaseW-1:0] CodeAddr     = 3'd1;
  localparam logic [PhaseW-1:0] CodeAddrAck  = 3'd2;
  localparam logic [PhaseW-1:0] CodeData     = 3'd3;
  localparam logic [PhaseW-1:0] CodeDataAck  = 3'd4;
  localparam logic [PhaseW-1:0] CodeWaitStop = 3'd5;

  typedef enum logic [5:0] {
    PhIdle     = 6'b000001,
    PhAddr     = 6'b000010,
    PhAddrAck  = 6'b000100,
    PhData     = 6'b001000,
    PhDataAck  = 6'b010000,
    PhWaitStop = 6'b100000
  } phase_e;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      PhIdle:     code = CodeIdle;
      PhAddr:     code = CodeAddr;
      PhAddrAck:  code = CodeAddrAck;
      PhData:     code = CodeData;
      PhDataAck:  code = CodeDataAck;
      PhWaitStop: code = CodeWaitStop;
      default:    code = CodeIdle;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_tbr_if.sv =====
// channel interfaces: line sample in, result out, address register write
`default_nettype none

interface i2c_tbr_in_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;

  modport source (output valid, output scl, output sda, input ready);
  modport sink (input valid, input scl, input sda, output ready);
endinterface

interface i2c_tbr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             sda_pull_low;
  logic                             start_seen;
  logic                             stop_seen;
  logic                             address_matched;
  logic                             address_rejected;
  logic                             byte_valid;
  logic [i2c_tbr_pkg::ByteW-1:0]    byte_value;
  logic [i2c_tbr_pkg::PhaseW-1:0]   bus_phase;

  modport source (
    output valid, output sda_pull_low, output start_seen, output stop_seen,
    output address_matched, output address_rejected, output byte_valid,
    output byte_value, output bus_phase, input ready
  );
  modport sink (
    input valid, input sda_pull_low, input start_seen, input stop_seen,
    input address_matched, input address_rejected, input byte_valid,
    input byte_value, input bus_phase, output ready
  );
endinterface

interface i2c_tbr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [i2c_tbr_pkg::AddrW-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2c_target_byte_receiver.sv =====
// i2c target byte receiver: start/stop detect, address match, one data byte
// a result beat is registered and presented in the cycle after its input beat is accepted
// throughput: one beat per cycle while the output is ready, set by the single result register
// input ready stays high while the result register is empty or being drained
// reset: bus lines assumed idle high, phase idle, own address 80, held byte 0
`default_nettype none

`include "i2c_target_byte_receiver_defines.svh"

module i2c_target_byte_receiver (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  i2c_tbr_in_if.sink            in_i,
  i2c_tbr_out_if.source         out_o,
  i2c_tbr_cfg_if.sink           cfg_i
);

  localparam int unsigned AddrW  = i2c_tbr_pkg::AddrW;
  localparam int unsigned ByteW  = i2c_tbr_pkg::ByteW;
  localparam int unsigned PhaseW = i2c_tbr_pkg::PhaseW;
  localparam int unsigned CountW = i2c_tbr_pkg::CountW;

  // bus state
  logic                     scl_last_q;
  logic                     sda_last_q;
  i2c_tbr_pkg::phase_e      phase_q, phase_d;
  logic [CountW-1:0]        bit_count_q, bit_count_d;
  logic [ByteW-1:0]         shift_q, shift_d;
  logic                     ack_drive_q, ack_drive_d;
  logic [ByteW-1:0]         held_byte_q, held_byte_d;
  logic [AddrW-1:0]         own_addr_q;

  // result register
  logic                     out_valid_q;
  logic                     start_q, stop_q, matched_q, rejected_q, byte_valid_q;
  logic [PhaseW-1:0]        bus_phase_q;

  logic                     in_fire;
  logic                     scl, sda;
  logic                     rising, falling, high_both, start, stop;
  logic                     matched, rejected, byte_valid;
  logic [CountW-1:0]        bit_count_inc;
  logic [ByteW-1:0]         shift_next;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign in_fire     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign scl = in_i.scl;
  assign sda = in_i.sda;

  assign rising    = scl & ~scl_last_q;
  assign falling   = ~scl & scl_last_q;
  assign high_both = scl & scl_last_q;
  assign start     = high_both & sda_last_q & ~sda;
  assign stop      = high_both & ~sda_last_q & sda;

  assign bit_count_inc = bit_count_q + CountW'(1);
  assign shift_next    = {shift_q[ByteW-2:0], sda};

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    ack_drive_d = ack_drive_q;
    held_byte_d = held_byte_q;
    matched     = 1'b0;
    rejected    = 1'b0;
    byte_valid  = 1'b0;
    if (start) begin
      phase_d     = i2c_tbr_pkg::PhAddr;
      bit_count_d = '0;
      shift_d     = '0;
      ack_drive_d = 1'b0;
    end else if (stop) begin
      phase_d     = i2c_tbr_pkg::PhIdle;
      bit_count_d = '0;
      ack_drive_d = 1'b0;
    end else begin
      unique case (phase_q) inside
        i2c_tbr_pkg::PhAddr, i2c_tbr_pkg::PhData: begin
          if (rising) begin
            shift_d     = shift_next;
            bit_count_d = bit_count_inc;
            if (bit_count_inc[CountW-1]) begin
              bit_count_d = '0;
              shift_d     = '0;
              if (phase_q == i2c_tbr_pkg::PhAddr) begin
                if (shift_next[ByteW-1:1] == own_addr_q && !shift_next[0]) begin
                  matched = 1'b1;
                  phase_d = i2c_tbr_pkg::PhAddrAck;
                end else begin
                  rejected = 1'b1;
                  phase_d  = i2c_tbr_pkg::PhWaitStop;
                end
              end else begin
                held_byte_d = shift_next;
                byte_valid  = 1'b1;
                phase_d     = i2c_tbr_pkg::PhDataAck;
              end
            end
          end
        end
        i2c_tbr_pkg::PhAddrAck, i2c_tbr_pkg::PhDataAck: begin
          if (falling) begin
            ack_drive_d = ~ack_drive_q;
            // end of the acknowledge clock
            if (ack_drive_q) begin
              if (phase_q == i2c_tbr_pkg::PhAddrAck) begin
                phase_d     = i2c_tbr_pkg::PhData;
                bit_count_d = '0;
                shift_d     = '0;
              end else begin
                phase_d = i2c_tbr_pkg::PhWaitStop;
              end
            end
          end
        end
        i2c_tbr_pkg::PhWaitStop: begin
        end
        default: begin
          phase_d     = i2c_tbr_pkg::PhIdle;
          ack_drive_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_last_q  <= 1'b1;
      sda_last_q  <= 1'b1;
      phase_q     <= i2c_tbr_pkg::PhIdle;
      bit_count_q <= '0;
      shift_q     <= '0;
      ack_drive_q <= 1'b0;
      held_byte_q <= '0;
    end else if (in_fire) begin
      scl_last_q  <= scl;
      sda_last_q  <= sda;
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      ack_drive_q <= ack_drive_d;
      held_byte_q <= held_byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= i2c_tbr_pkg::OwnAddrReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      own_addr_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q      <= start;
      stop_q       <= stop;
      matched_q    <= matched;
      rejected_q   <= rejected;
      byte_valid_q <= byte_valid;
      bus_phase_q  <= i2c_tbr_pkg::phase_code(phase_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.sda_pull_low     = ack_drive_q;
  assign out_o.start_seen       = start_q;
  assign out_o.stop_seen        = stop_q;
  assign out_o.address_matched  = matched_q;
  assign out_o.address_rejected = rejected_q;
  assign out_o.byte_valid       = byte_valid_q;
  assign out_o.byte_value       = held_byte_q;
  assign out_o.bus_phase        = bus_phase_q;

  `I2C_TBR_ASSERT_NEVER(a_match_and_reject, out_valid_q && matched_q && rejected_q, "address both matched and rejected")
  `I2C_TBR_ASSERT(a_ack_only_in_ack_phase, ack_drive_q |-> (phase_q == i2c_tbr_pkg::PhAddrAck || phase_q == i2c_tbr_pkg::PhDataAck), "sda driven outside an ack phase")
  `I2C_TBR_ASSERT(a_byte_enters_data_ack, (out_valid_q && byte_valid_q) |-> (bus_phase_q == i2c_tbr_pkg::CodeDataAck), "byte beat not followed by data ack phase")
  `I2C_TBR_ASSERT(a_start_enters_addr, (out_valid_q && start_q) |-> (bus_phase_q == i2c_tbr_pkg::CodeAddr && !ack_drive_q), "start beat not in address phase")

endmodule

`default_nettype wire
